// ----- rtl/vlr_pkg.sv -----
// Shared types, sizes and codes for the VGA line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package vlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int CMPX_BITS  = COORD_BITS + 1;

  localparam int POINTS_PER_ITEM = 64;
  localparam int BUDGET_BITS     = $clog2(POINTS_PER_ITEM);

  // power of two so the queue pointers wrap on their own
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam int PLANAR_W = 640;
  localparam int PLANAR_H = 480;
  localparam int LINEAR_W = 320;
  localparam int LINEAR_H = 200;
  localparam int LINP_BITS = 19;
  localparam int ADDR_BITS = 16;

  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_PLANAR = 2'd1;
  localparam logic [1:0] MODE_LINEAR = 2'd2;

  localparam logic [1:0] ST_PLOT  = 2'd0;
  localparam logic [1:0] ST_CLIP  = 2'd1;
  localparam logic [1:0] ST_NOGFX = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [7:0]                   pixel_colour;
  } line_cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] byte_address;
    logic [2:0]           bit_position;
    logic [3:0]           plane_bits;
    logic [7:0]           pixel_byte;
    logic                 last_point;
  } point_res_t;

  typedef struct packed {
    logic                         is_err;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [DELTA_BITS-1:0]        abs_dx;
    logic signed [DELTA_BITS-1:0] neg_abs_dy;
    logic [1:0]                   step_signs;
    logic [7:0]                   colour;
  } q_entry_t;

endpackage
`default_nettype wire

// ----- rtl/vga_line_rasterizer.sv -----
// Top level of the VGA line rasterizer: mode register, front end, queue, walker.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    in_data  (line_cmd_t)
//   out       output     out_valid / out_ready  out_data (point_res_t)
//   cfg       input      cfg_wr_en              cfg_wr_data (video_mode)
//
// Each line command is taken from the queue by the walker, which then emits
// one Bresenham point per cycle while the out channel is not stalled, and takes
// another command only when that transaction is finished.
// A line longer than 64 points continues on the following transactions, whose
// payload is then dropped. Reset clears the mode to text, empties the queue
// and abandons any line. A stalled out channel holds the walker; the queue
// keeps taking commands until it is full.
`timescale 1ns / 1ps
`default_nettype none
module vga_line_rasterizer import vlr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire line_cmd_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output point_res_t      out_data,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_wr_data
);

  logic [1:0] video_mode;
  q_entry_t   front_entry;
  q_entry_t   q_head;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  // Mode register; a write also abandons a line in progress (see walker).
  always_ff @(posedge clk) begin
    if (rst) begin
      video_mode <= MODE_TEXT;
    end else if (cfg_wr_en) begin
      video_mode <= cfg_wr_data;
    end
  end

  // Accept a command whenever the queue has room.
  assign in_ready = !q_full;

  vlr_front u_front (
    .mode  (video_mode),
    .cmd   (in_data),
    .entry (front_entry)
  );

  vlr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  vlr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (video_mode),
    .cfg_clear (cfg_wr_en),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/vlr_front.sv -----
// Front end: classifies a line command and precomputes its deltas.
`timescale 1ns / 1ps
`default_nettype none
module vlr_front import vlr_pkg::*; (
  input  wire logic [1:0] mode,
  input  wire line_cmd_t  cmd,
  output q_entry_t        entry
);

  logic signed [DELTA_BITS-1:0] dx;
  logic signed [DELTA_BITS-1:0] dy;

  always_comb begin
    dx = {cmd.end_x[COORD_BITS-1], cmd.end_x} - {cmd.start_x[COORD_BITS-1], cmd.start_x};
    dy = {cmd.end_y[COORD_BITS-1], cmd.end_y} - {cmd.start_y[COORD_BITS-1], cmd.start_y};
    entry.is_err     = (mode != MODE_PLANAR) && (mode != MODE_LINEAR);
    entry.start_x    = cmd.start_x;
    entry.start_y    = cmd.start_y;
    entry.end_x      = cmd.end_x;
    entry.end_y      = cmd.end_y;
    entry.abs_dx     = dx[DELTA_BITS-1] ? -dx : dx;
    entry.neg_abs_dy = dy[DELTA_BITS-1] ? dy : -dy;
    // step each coordinate by -1 unless its end value is strictly greater than its start
    entry.step_signs = {dy[DELTA_BITS-1] || (dy == '0), dx[DELTA_BITS-1] || (dx == '0)};
    entry.colour     = cmd.pixel_colour;
  end

endmodule
`default_nettype wire

// ----- rtl/vlr_fifo.sv -----
// Short command queue between the front end and the line walker.
`timescale 1ns / 1ps
`default_nettype none
module vlr_fifo import vlr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output q_entry_t      head
);

  q_entry_t              mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (count == Q_CNT_BITS'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// ----- rtl/vlr_back.sv -----
// Back end: Bresenham walker, address generation and result register.
`timescale 1ns / 1ps
`default_nettype none
module vlr_back import vlr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] mode,
  input  wire logic       cfg_clear,
  input  wire logic       q_valid,
  input  wire q_entry_t   q_head,
  output logic            q_pop,
  output logic            res_valid,
  input  wire logic       res_ready,
  output point_res_t      res_data
);

  localparam int EW = ERR_BITS;
  localparam int DW = DELTA_BITS;
  localparam int CW = COORD_BITS;

  logic                   walking;
  logic                   active;
  logic                   err_item;
  logic [BUDGET_BITS-1:0] budget;

  logic signed [CW-1:0]   cur_x;
  logic signed [CW-1:0]   cur_y;
  logic signed [CW-1:0]   target_x;
  logic signed [CW-1:0]   target_y;
  logic [DW-1:0]          abs_dx;
  logic signed [DW-1:0]   neg_abs_dy;
  logic signed [EW-1:0]   error_term;
  logic [1:0]             step_signs;
  logic [7:0]             held_colour;

  logic                   done;
  logic                   emit;
  logic                   load_line;
  logic signed [EW:0]     e2;
  logic signed [EW:0]     adx_w;
  logic signed [EW:0]     nady_w;
  logic                   step_x;
  logic                   step_y;
  logic [EW-1:0]          error_next;
  logic [EW-1:0]          error_init;
  logic [LINP_BITS-1:0]   lin_p;
  logic [ADDR_BITS-1:0]   lin_l;
  logic                   on_planar;
  logic                   on_linear;
  point_res_t             res;

  always_comb begin
    done      = (cur_x == target_x) && (cur_y == target_y);
    emit      = active && (!res_valid || res_ready);
    q_pop     = !active && !cfg_clear;
    load_line = q_pop && q_valid && !walking && !q_head.is_err;

    error_init = {{(EW-DW){1'b0}}, q_head.abs_dx}
               + {{(EW-DW){q_head.neg_abs_dy[DW-1]}}, q_head.neg_abs_dy};

    e2     = {error_term, 1'b0};
    adx_w  = {{(EW+1-DW){1'b0}}, abs_dx};
    nady_w = {{(EW+1-DW){neg_abs_dy[DW-1]}}, neg_abs_dy};
    step_x = (e2 >= nady_w);
    step_y = (e2 <= adx_w);
    error_next = error_term
               + (step_x ? nady_w[EW-1:0] : '0)
               + (step_y ? adx_w[EW-1:0] : '0);

    on_planar = !cur_x[CW-1] && !cur_y[CW-1]
             && ({1'b0, cur_x} < CMPX_BITS'(PLANAR_W))
             && ({1'b0, cur_y} < CMPX_BITS'(PLANAR_H));
    on_linear = !cur_x[CW-1] && !cur_y[CW-1]
             && ({1'b0, cur_x} < CMPX_BITS'(LINEAR_W))
             && ({1'b0, cur_y} < CMPX_BITS'(LINEAR_H));
    // x + 640y and x + 320y as shift-adds
    lin_p = LINP_BITS'(cur_x[9:0]) + (LINP_BITS'(cur_y[8:0]) << 9)
          + (LINP_BITS'(cur_y[8:0]) << 7);
    lin_l = ADDR_BITS'(cur_x[8:0]) + (ADDR_BITS'(cur_y[7:0]) << 8)
          + (ADDR_BITS'(cur_y[7:0]) << 6);

    res = '0;
    if (err_item) begin
      res.status     = ST_NOGFX;
      res.last_point = 1'b1;
    end else begin
      res.last_point = done;
      if (mode == MODE_PLANAR) begin
        if (on_planar) begin
          res.status       = ST_PLOT;
          res.byte_address = lin_p[LINP_BITS-1:3];
          res.bit_position = ~lin_p[2:0];
          res.plane_bits   = held_colour[3:0];
        end else begin
          res.status = ST_CLIP;
        end
      end else begin
        if (on_linear) begin
          res.status       = ST_PLOT;
          res.byte_address = lin_l;
          res.pixel_byte   = held_colour;
        end else begin
          res.status = ST_CLIP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking   <= 1'b0;
      active    <= 1'b0;
      err_item  <= 1'b0;
      budget    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (emit)           res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;

      if (cfg_clear) begin
        walking <= 1'b0;
      end else if (q_pop && q_valid) begin
        active <= 1'b1;
        budget <= '0;
        if (walking) begin
          err_item <= 1'b0;
        end else begin
          err_item <= q_head.is_err;
          if (!q_head.is_err) walking <= 1'b1;
        end
      end else if (emit) begin
        if (err_item) begin
          active <= 1'b0;
        end else begin
          budget <= budget + 1'b1;
          if (done) begin
            walking <= 1'b0;
            active  <= 1'b0;
          end else if (budget == BUDGET_BITS'(POINTS_PER_ITEM - 1)) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_line) begin
      cur_x       <= q_head.start_x;
      cur_y       <= q_head.start_y;
      target_x    <= q_head.end_x;
      target_y    <= q_head.end_y;
      abs_dx      <= q_head.abs_dx;
      neg_abs_dy  <= q_head.neg_abs_dy;
      step_signs  <= q_head.step_signs;
      held_colour <= q_head.colour;
      error_term  <= error_init;
    end else if (emit && !err_item && !done) begin
      error_term <= error_next;
      if (step_x) cur_x <= cur_x + (step_signs[0] ? {CW{1'b1}} : CW'(1));
      if (step_y) cur_y <= cur_y + (step_signs[1] ? {CW{1'b1}} : CW'(1));
    end
    if (emit) res_data <= res;
  end

endmodule
`default_nettype wire
